FILE: rtl/ncps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncps_pkg
// Shared constants, types and arithmetic helpers for the nearest camera
// pixel select pipeline.
// ----------------------------------------------------------------------------
package ncps_pkg;

  localparam int NUM_CAMS    = 4;
  localparam int CAM_IDX_W   = 2;
  localparam int COORD_W     = 11;
  localparam int COORD_LIMIT = 2048;
  localparam int PIXEL_W     = 24;
  localparam int CFG_INDEX_W = 4;

  // Sum of two squared coordinate differences, padded to an even width for the
  // two-bits-per-step square root.
  localparam int SQ_W  = 2 * COORD_W + 1;
  localparam int RAD_W = SQ_W + (SQ_W % 2);
  localparam int DIST_W = RAD_W / 2;
  localparam int REM_W  = DIST_W + 1;

  localparam int SQRT_STEPS_PER_STAGE = 3;
  localparam int SQRT_STAGES = DIST_W / SQRT_STEPS_PER_STAGE;

  // Largest floored distance between two clamped points.
  localparam int DIST_BOUND = 2894;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAM0_X = 4'd0,
    REG_CAM0_Y = 4'd1,
    REG_CAM1_X = 4'd2,
    REG_CAM1_Y = 4'd3,
    REG_CAM2_X = 4'd4,
    REG_CAM2_Y = 4'd5,
    REG_CAM3_X = 4'd6,
    REG_CAM3_Y = 4'd7
  } cfg_reg_e;

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [PIXEL_W-1:0]   pixel_t;
  typedef logic [SQ_W-1:0]      sq_t;
  typedef logic [DIST_W-1:0]    dist_t;
  typedef logic [CAM_IDX_W-1:0] cam_idx_t;

  typedef coord_t [NUM_CAMS-1:0] cam_coord_t;
  typedef pixel_t [NUM_CAMS-1:0] pix_arr_t;
  typedef sq_t    [NUM_CAMS-1:0] sq_arr_t;
  typedef dist_t  [NUM_CAMS-1:0] dist_arr_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    dist_t            root;
  } sqrt_lane_t;

  typedef sqrt_lane_t [NUM_CAMS-1:0] sqrt_arr_t;

  typedef struct packed {
    pixel_t   pixel;
    cam_idx_t idx;
    dist_t    distance;
  } pick_t;

  localparam coord_t CAM_X_RESET [NUM_CAMS] = '{11'd625, 11'd625, 11'd500, 11'd750};
  localparam coord_t CAM_Y_RESET [NUM_CAMS] = '{11'd500, 11'd1300, 11'd800, 11'd800};

  function automatic coord_t clamp_coord(input coord_t v);
    if ((COORD_W + 2)'(v) >= (COORD_W + 2)'(COORD_LIMIT)) begin
      return COORD_W'(COORD_LIMIT - 1);
    end
    return v;
  endfunction

  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // One restoring square root step: brings in the next two radicand bits and
  // decides one root bit.
  function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t s);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    sqrt_lane_t       r;
    cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = (REM_W + 2)'({s.root, 2'b01});
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      r.rem  = REM_W'(cur - trial);
      r.root = {s.root[DIST_W-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(cur);
      r.root = {s.root[DIST_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/nearest_camera_pixel_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_camera_pixel_select
// Picks, for each output pixel, the pixel of the nearest of four cameras.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per output pixel, carrying the
//   pixel position (col, row) and the four camera pixels at that position.
//   Output channel (out_valid/out_ready): one beat per input beat, in order,
//   with the chosen pixel, the camera index and the floored distance.
//   Configuration channel (cfg_valid/cfg_ready): cfg_index selects one of the
//   eight camera coordinate registers; indexes above seven are dropped.
//   cfg_ready is always high. Write only while the pipeline is empty.
//   An input beat reaches the output through two stages of
//   difference and sum of squares, four stages of the square root at three
//   root bits per stage, and two stages of the minimum tree.
//   Throughput is one beat per cycle. The whole pipeline advances together;
//   when the output register holds a beat that is not taken, every stage
//   holds and in_ready drops, so nothing is lost or repeated.
//   Synchronous reset empties the pipeline and loads the default camera
//   positions.
// ----------------------------------------------------------------------------
module nearest_camera_pixel_select (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ncps_pkg::coord_t                col,
  input  ncps_pkg::coord_t                row,
  input  ncps_pkg::pixel_t                pixel_src0,
  input  ncps_pkg::pixel_t                pixel_src1,
  input  ncps_pkg::pixel_t                pixel_src2,
  input  ncps_pkg::pixel_t                pixel_src3,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ncps_pkg::pixel_t                pixel_out,
  output ncps_pkg::cam_idx_t              chosen_source,
  output ncps_pkg::dist_t                 nearest_distance,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ncps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  ncps_pkg::coord_t                cfg_data
);
  import ncps_pkg::*;

  localparam int PIX_DELAY = 2 + SQRT_STAGES;

  logic       en;
  cam_coord_t cam_x;
  cam_coord_t cam_y;
  sq_arr_t    sq;
  logic       sq_valid;
  sqrt_arr_t  sqrt_lanes [SQRT_STAGES+1];
  logic       sqrt_valid [SQRT_STAGES+1];
  dist_arr_t  dists;
  pix_arr_t   pix_pipe [PIX_DELAY];

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CAMS; i++) begin
        cam_x[i] <= CAM_X_RESET[i];
        cam_y[i] <= CAM_Y_RESET[i];
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAM0_X: cam_x[0] <= cfg_data;
        REG_CAM0_Y: cam_y[0] <= cfg_data;
        REG_CAM1_X: cam_x[1] <= cfg_data;
        REG_CAM1_Y: cam_y[1] <= cfg_data;
        REG_CAM2_X: cam_x[2] <= cfg_data;
        REG_CAM2_Y: cam_y[2] <= cfg_data;
        REG_CAM3_X: cam_x[3] <= cfg_data;
        REG_CAM3_Y: cam_y[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Camera pixels ride alongside the distance computation.
  always_ff @(posedge clk) begin
    if (en) begin
      pix_pipe[0] <= {pixel_src3, pixel_src2, pixel_src1, pixel_src0};
      for (int s = 1; s < PIX_DELAY; s++) begin
        pix_pipe[s] <= pix_pipe[s-1];
      end
    end
  end

  ncps_dist_sq u_dist_sq (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (in_valid),
    .col       (col),
    .row       (row),
    .cam_x     (cam_x),
    .cam_y     (cam_y),
    .valid_out (sq_valid),
    .sq        (sq)
  );

  always_comb begin
    for (int i = 0; i < NUM_CAMS; i++) begin
      sqrt_lanes[0][i].rad  = RAD_W'(sq[i]);
      sqrt_lanes[0][i].rem  = '0;
      sqrt_lanes[0][i].root = '0;
    end
  end
  assign sqrt_valid[0] = sq_valid;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    ncps_sqrt_stage u_sqrt_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (sqrt_valid[g]),
      .lanes_in  (sqrt_lanes[g]),
      .valid_out (sqrt_valid[g+1]),
      .lanes_out (sqrt_lanes[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_CAMS; i++) begin
      dists[i] = sqrt_lanes[SQRT_STAGES][i].root;
    end
  end

  ncps_select u_select (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .valid_in         (sqrt_valid[SQRT_STAGES]),
    .dists            (dists),
    .pix              (pix_pipe[PIX_DELAY-1]),
    .valid_out        (out_valid),
    .pixel_out        (pixel_out),
    .chosen_source    (chosen_source),
    .nearest_distance (nearest_distance)
  );

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty output register");

  a_distance_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> nearest_distance <= DIST_W'(DIST_BOUND))
    else $error("nearest distance beyond the largest possible value");

endmodule

FILE: rtl/ncps_dist_sq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncps_dist_sq
// Two stages: clamped absolute coordinate differences, then the sum of their
// squares for each of the four cameras.
// ----------------------------------------------------------------------------
module ncps_dist_sq (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  ncps_pkg::coord_t     col,
  input  ncps_pkg::coord_t     row,
  input  ncps_pkg::cam_coord_t cam_x,
  input  ncps_pkg::cam_coord_t cam_y,
  output logic                valid_out,
  output ncps_pkg::sq_arr_t    sq
);
  import ncps_pkg::*;

  cam_coord_t dx;
  cam_coord_t dy;
  logic       diff_valid;
  coord_t     px;
  coord_t     py;

  assign px = clamp_coord(col);
  assign py = clamp_coord(row);

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      valid_out  <= 1'b0;
    end else if (en) begin
      diff_valid <= valid_in;
      valid_out  <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_CAMS; i++) begin
        dx[i] <= abs_diff(px, clamp_coord(cam_x[i]));
        dy[i] <= abs_diff(py, clamp_coord(cam_y[i]));
        sq[i] <= SQ_W'(dx[i] * dx[i]) + SQ_W'(dy[i] * dy[i]);
      end
    end
  end

endmodule

FILE: rtl/ncps_sqrt_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncps_sqrt_stage
// One register stage of the pipelined integer square root, several root bits
// per stage, four lanes side by side.
// ----------------------------------------------------------------------------
module ncps_sqrt_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  ncps_pkg::sqrt_arr_t  lanes_in,
  output logic                valid_out,
  output ncps_pkg::sqrt_arr_t  lanes_out
);
  import ncps_pkg::*;

  sqrt_arr_t lanes_next;

  always_comb begin
    lanes_next = lanes_in;
    for (int s = 0; s < SQRT_STEPS_PER_STAGE; s++) begin
      for (int i = 0; i < NUM_CAMS; i++) begin
        lanes_next[i] = sqrt_step(lanes_next[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_out <= lanes_next;
    end
  end

endmodule

FILE: rtl/ncps_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncps_select
// Two-level minimum tree over the four distances, lower index winning ties,
// ending in the output register.
// ----------------------------------------------------------------------------
module ncps_select (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  ncps_pkg::dist_arr_t  dists,
  input  ncps_pkg::pix_arr_t   pix,
  output logic                valid_out,
  output ncps_pkg::pixel_t     pixel_out,
  output ncps_pkg::cam_idx_t   chosen_source,
  output ncps_pkg::dist_t      nearest_distance
);
  import ncps_pkg::*;

  pick_t pair_pick [2];
  logic  pair_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      valid_out  <= 1'b0;
    end else if (en) begin
      pair_valid <= valid_in;
      valid_out  <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 2; p++) begin
        if (dists[2*p+1] < dists[2*p]) begin
          pair_pick[p] <= '{pixel: pix[2*p+1], idx: CAM_IDX_W'(2*p+1),
                            distance: dists[2*p+1]};
        end else begin
          pair_pick[p] <= '{pixel: pix[2*p], idx: CAM_IDX_W'(2*p),
                            distance: dists[2*p]};
        end
      end
      if (pair_pick[1].distance < pair_pick[0].distance) begin
        pixel_out        <= pair_pick[1].pixel;
        chosen_source    <= pair_pick[1].idx;
        nearest_distance <= pair_pick[1].distance;
      end else begin
        pixel_out        <= pair_pick[0].pixel;
        chosen_source    <= pair_pick[0].idx;
        nearest_distance <= pair_pick[0].distance;
      end
    end
  end

endmodule

FILE: bench/nearest_camera_pixel_select_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_camera_pixel_select_tb
// Self-checking bench for the nearest camera pixel select pipeline. It runs
// directed and random pixel beats under several camera placements and three
// flow control mixes. A scoreboard predicts the camera choice, the pixel and
// the floored distance for every input beat and compares them, in order, with
// the output beats.
// ----------------------------------------------------------------------------
module nearest_camera_pixel_select_tb;

  import ncps_pkg::*;

  localparam int     PIPE_LATENCY   = 8;
  localparam int     RESET_CYCLES   = 6;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     MAX_REPORTS    = 10;
  localparam int     NUM_PHASES     = 3;
  localparam int     RANDOM_BEATS   = 130;
  localparam coord_t COORD_TOP      = '1;
  localparam pixel_t PIX_ONES       = '1;
  localparam pixel_t PIX_ZERO       = '0;

  localparam int TX_IDLE [NUM_PHASES] = '{26, 73, 0};
  localparam int RX_IDLE [NUM_PHASES] = '{73, 26, 0};

  localparam cfg_reg_e X_REG [NUM_CAMS] = '{REG_CAM0_X, REG_CAM1_X, REG_CAM2_X, REG_CAM3_X};
  localparam cfg_reg_e Y_REG [NUM_CAMS] = '{REG_CAM0_Y, REG_CAM1_Y, REG_CAM2_Y, REG_CAM3_Y};

  class nearest_pick_scoreboard;
    coord_t cam_x [NUM_CAMS];
    coord_t cam_y [NUM_CAMS];
    pick_t  picks_due [$];
    int     errors;

    function new();
      cam_x  = '{11'd625, 11'd625, 11'd500, 11'd750};
      cam_y  = '{11'd500, 11'd1300, 11'd800, 11'd800};
      errors = 0;
    endfunction

    function coord_t limit_coord(int unsigned v);
      if (v >= COORD_LIMIT) begin
        return coord_t'(COORD_LIMIT - 1);
      end
      return coord_t'(v);
    endfunction

    // Largest r with r*r <= v, found by bisection.
    function int unsigned floor_root(int unsigned v);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= v) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      return lo;
    endfunction

    function pick_t nearest_pick(coord_t c, coord_t r, pix_arr_t src);
      pick_t       best;
      int          dx;
      int          dy;
      int unsigned d;
      best.distance = '1;
      best.idx      = '0;
      best.pixel    = src[0];
      for (int k = 0; k < NUM_CAMS; k++) begin
        dx = int'(limit_coord(c)) - int'(limit_coord(cam_x[k]));
        dy = int'(limit_coord(r)) - int'(limit_coord(cam_y[k]));
        d  = floor_root(int'(dx * dx + dy * dy));
        if (d > 4095) begin
          d = 4095;
        end
        // Strictly smaller only, so the lower camera keeps a tie.
        if (k == 0 || d < best.distance) begin
          best.distance = dist_t'(d);
          best.idx      = cam_idx_t'(k);
          best.pixel    = src[k];
        end
      end
      return best;
    endfunction

    function void note_cam_write(logic [CFG_INDEX_W-1:0] idx, coord_t val);
      if (idx <= REG_CAM3_Y) begin
        if (idx[0]) begin
          cam_y[idx >> 1] = val;
        end else begin
          cam_x[idx >> 1] = val;
        end
      end
    endfunction

    function void note_pixel(coord_t c, coord_t r, pix_arr_t src);
      picks_due = {picks_due, nearest_pick(c, r, src)};
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%t ERROR: %s", $realtime, msg);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        flag($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
      end
    endfunction

    function void check_pick(pixel_t pix, cam_idx_t idx, dist_t distance);
      pick_t want;
      if (picks_due.size() == 0) begin
        flag($sformatf("output beat with nothing pending: pixel 0x%0h source %0d dist %0d",
                       pix, idx, distance));
        return;
      end
      want = picks_due.pop_front();
      compare_field("pixel_out", 32'(want.pixel), 32'(pix));
      compare_field("chosen_source", 32'(want.idx), 32'(idx));
      compare_field("nearest_distance", 32'(want.distance), 32'(distance));
    endfunction

    function void finish_check();
      if (picks_due.size() != 0) begin
        flag($sformatf("%0d output beats never arrived", picks_due.size()));
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  coord_t   col = '0;
  coord_t   row = '0;
  pixel_t   pixel_src0 = '0;
  pixel_t   pixel_src1 = '0;
  pixel_t   pixel_src2 = '0;
  pixel_t   pixel_src3 = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pixel_t   pixel_out;
  cam_idx_t chosen_source;
  dist_t    nearest_distance;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  coord_t   cfg_data = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;

  nearest_pick_scoreboard picks = new();

  nearest_camera_pixel_select i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .col              (col),
    .row              (row),
    .pixel_src0       (pixel_src0),
    .pixel_src1       (pixel_src1),
    .pixel_src2       (pixel_src2),
    .pixel_src3       (pixel_src3),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .pixel_out        (pixel_out),
    .chosen_source    (chosen_source),
    .nearest_distance (nearest_distance),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Handshakes are sampled at the edge, before any flop of the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        picks.note_cam_write(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        picks.note_pixel(col, row, {pixel_src3, pixel_src2, pixel_src1, pixel_src0});
      end
      if (out_valid && out_ready) begin
        picks.check_pick(pixel_out, chosen_source, nearest_distance);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic pix_arr_t random_pixels();
    pix_arr_t p;
    for (int k = 0; k < NUM_CAMS; k++) begin
      p[k] = pixel_t'($urandom);
    end
    return p;
  endfunction

  function automatic coord_t nudge(coord_t v);
    int t;
    t = int'(v) + int'($urandom_range(8)) - 4;
    if (t < 0) begin
      t = 0;
    end
    if (t > int'(COORD_TOP)) begin
      t = int'(COORD_TOP);
    end
    return coord_t'(t);
  endfunction

  function automatic coord_t extreme_or_random();
    case ($urandom_range(2))
      0: begin
        return '0;
      end
      1: begin
        return COORD_TOP;
      end
      default: begin
        return coord_t'($urandom_range(COORD_TOP));
      end
    endcase
  endfunction

  task automatic send_pixel(coord_t c, coord_t r, pix_arr_t src);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    col        <= c;
    row        <= r;
    pixel_src0 <= src[0];
    pixel_src1 <= src[1];
    pixel_src2 <= src[2];
    pixel_src3 <= src[3];
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Most random beats land near a camera or halfway between two, where the
  // distance comparison and the tie rule actually matter.
  task automatic send_random_pixel();
    int     mode;
    int     a;
    int     b;
    coord_t c;
    coord_t r;
    mode = $urandom_range(99);
    a    = $urandom_range(NUM_CAMS - 1);
    b    = $urandom_range(NUM_CAMS - 1);
    if (mode < 45) begin
      c = nudge(picks.cam_x[a]);
      r = nudge(picks.cam_y[a]);
    end else if (mode < 70) begin
      c = nudge(coord_t'((int'(picks.cam_x[a]) + int'(picks.cam_x[b])) / 2));
      r = nudge(coord_t'((int'(picks.cam_y[a]) + int'(picks.cam_y[b])) / 2));
    end else if (mode < 80) begin
      c = $urandom_range(1) ? COORD_TOP : coord_t'(0);
      r = $urandom_range(1) ? COORD_TOP : coord_t'(0);
    end else begin
      c = coord_t'($urandom_range(COORD_TOP));
      r = coord_t'($urandom_range(COORD_TOP));
    end
    send_pixel(c, r, random_pixels());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (picks.picks_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_cam_reg(logic [CFG_INDEX_W-1:0] idx, coord_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic place_cameras(cam_coord_t xs, cam_coord_t ys);
    for (int k = 0; k < NUM_CAMS; k++) begin
      write_cam_reg(X_REG[k], xs[k]);
      write_cam_reg(Y_REG[k], ys[k]);
    end
  endtask

  initial begin
    cam_coord_t xs;
    cam_coord_t ys;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = TX_IDLE[0];
    rx_idle_pct = RX_IDLE[0];

    // Writes to indexes past the last camera register must change nothing.
    for (int k = 1; k <= 8; k++) begin
      write_cam_reg(CFG_INDEX_W'(REG_CAM3_Y) + CFG_INDEX_W'(k), coord_t'($urandom));
    end

    // Default placement: every camera hit exactly, two tie points between the
    // left and right cameras, and the four corners.
    send_pixel(11'd625, 11'd500, {PIX_ONES, PIX_ONES, PIX_ZERO, PIX_ONES});
    send_pixel(11'd625, 11'd1300, random_pixels());
    send_pixel(11'd500, 11'd800, random_pixels());
    send_pixel(11'd750, 11'd800, random_pixels());
    send_pixel(11'd625, 11'd800, random_pixels());
    send_pixel(11'd625, 11'd900, random_pixels());
    send_pixel(11'd0, 11'd0, {PIX_ZERO, PIX_ONES, PIX_ZERO, PIX_ONES});
    send_pixel(COORD_TOP, 11'd0, {PIX_ONES, PIX_ZERO, PIX_ONES, PIX_ZERO});
    send_pixel(11'd0, COORD_TOP, {PIX_ZERO, PIX_ZERO, PIX_ONES, PIX_ZERO});
    send_pixel(COORD_TOP, COORD_TOP, {PIX_ONES, PIX_ONES, PIX_ONES, PIX_ONES});
    wait_drained();

    // Cluster at the origin: a closer camera can lose to a lower index once
    // both distances floor to the same value.
    xs = {COORD_TOP, 11'd0, 11'd1, 11'd1};
    ys = {COORD_TOP, 11'd2, 11'd0, 11'd1};
    place_cameras(xs, ys);
    send_pixel(11'd0, 11'd0, random_pixels());
    send_pixel(11'd0, 11'd1, random_pixels());
    send_pixel(11'd1, 11'd0, random_pixels());
    send_pixel(COORD_TOP, 11'd0, random_pixels());
    send_pixel(COORD_TOP, COORD_TOP, random_pixels());
    wait_drained();

    // All cameras on the origin gives the longest possible distance.
    place_cameras('0, '0);
    send_pixel(COORD_TOP, COORD_TOP, random_pixels());
    send_pixel(11'd0, 11'd0, random_pixels());
    wait_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      tx_idle_pct = TX_IDLE[phase];
      rx_idle_pct = RX_IDLE[phase];
      for (int k = 0; k < NUM_CAMS; k++) begin
        case (phase)
          0: begin
            xs[k] = coord_t'($urandom_range(COORD_TOP));
            ys[k] = coord_t'($urandom_range(COORD_TOP));
          end
          1: begin
            xs[k] = k[0] ? COORD_TOP : coord_t'(0);
            ys[k] = k[1] ? COORD_TOP : coord_t'(0);
          end
          default: begin
            xs[k] = extreme_or_random();
            ys[k] = extreme_or_random();
          end
        endcase
      end
      place_cameras(xs, ys);
      for (int n = 0; n < RANDOM_BEATS; n++) begin
        if ($urandom_range(39) == 0) begin
          wait_drained();
        end
        send_random_pixel();
      end
      wait_drained();
    end

    picks.finish_check();
    if (picks.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
